// ===== design/fz0ves_pkg.sv =====
// Package with the constants, widths and stage numbers of the FZ0 loss pipeline.
package fz0ves_pkg;

	localparam int FRAC_BITS  = 24;
	localparam int ALPHA_BITS = 24;
	localparam int LOG_Q      = 30;
	localparam int IN_W       = 32;
	localparam int SCORE_W    = 48;

	localparam logic [27:0] LN2_Q28 = 28'd186065279;
	localparam logic [ALPHA_BITS-1:0] TAIL_RESET = ALPHA_BITS'(838861);

	localparam int QA_W   = IN_W + ALPHA_BITS;
	localparam int QB_W   = 61;
	localparam int CAP_SH = QB_W - FRAC_BITS;
	localparam int RND_SH = 58 - FRAC_BITS;
	localparam int LN_W   = FRAC_BITS + 7;
	localparam int LS_W   = LN_W + 2;
	localparam int IM_W   = 57;
	localparam int INR_W  = IM_W + 1;
	localparam int MAG_W  = 35;
	localparam int MAG_LO = 17;
	localparam int HI_W   = MAG_W - MAG_LO + 28;
	localparam int LO_W   = MAG_LO + 28;
	localparam int PR_W   = MAG_W + 28;
	localparam int TM_W   = QB_W + 2;
	localparam int SUM_W  = 64;

	localparam logic signed [SUM_W-1:0] SUM_MAX = (SUM_W'(1) <<< (SCORE_W - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] SUM_MIN = -(SUM_W'(1) <<< (SCORE_W - 1));

	localparam int ST_NORM  = 1;
	localparam int ST_L     = ST_NORM + LOG_Q + 1;
	localparam int ST_PART  = ST_L + 1;
	localparam int ST_PROD  = ST_PART + 1;
	localparam int ST_RND   = ST_PROD + 1;
	localparam int ST_LNSUM = ST_RND + 1;
	localparam int ST_INNER = QA_W + 1;
	localparam int ST_MAG   = ST_INNER + 1;
	localparam int ST_CAP   = ST_MAG + 1;
	localparam int ST_TERM  = ST_CAP + QB_W + 1;
	localparam int ST_SUM   = ST_TERM + 1;
	localparam int ST_OUT   = ST_SUM + 1;

endpackage

// ===== design/fz0_var_es_loss_top.sv =====
// Top level of the FZ0 joint VaR and ES loss pipeline.

// The block takes one transfer in every cycle while the output is not stalled and returns each score in order.
// The pipeline depth is set by two restoring dividers, one quotient bit per stage: the 56-bit hit
// quotient and the 61-bit scaled term quotient, with the two logarithms computed by 30 squaring
// stages alongside the first divider. A stall at the output holds the whole pipeline.
module fz0_var_es_loss_top import fz0ves_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ALPHA_BITS-1:0]     cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [IN_W-1:0]    var_forecast,
	input  logic signed [IN_W-1:0]    es_forecast,
	input  logic signed [IN_W-1:0]    realized_return,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [SCORE_W-1:0] score,
	output logic                      invalid,
	output logic                      saturated
);

	typedef struct packed {
		logic                     inv;
		logic signed [IN_W-1:0]   es;
		logic signed [IN_W-1:0]   vr;
		logic [ALPHA_BITS-1:0]    a;
		logic [IN_W-1:0]          e;
		logic [ALPHA_BITS-1:0]    ra;
		logic [QA_W-1:0]          qa;
		logic [ALPHA_BITS-1:0]    v2;
		logic [LOG_Q:0]           m1;
		logic [LOG_Q:0]           m2;
		logic [4:0]               p1;
		logic [4:0]               p2;
		logic [LOG_Q-1:0]         f1;
		logic [LOG_Q-1:0]         f2;
		logic                     n1;
		logic                     n2;
		logic [MAG_W-1:0]         mag1;
		logic [MAG_W-1:0]         mag2;
		logic [HI_W-1:0]          hi1;
		logic [HI_W-1:0]          hi2;
		logic [LO_W-1:0]          lo1;
		logic [LO_W-1:0]          lo2;
		logic [PR_W-1:0]          pr1;
		logic [PR_W-1:0]          pr2;
		logic signed [LN_W-1:0]   ln1;
		logic signed [LN_W-1:0]   ln2;
		logic signed [LS_W-1:0]   lns;
		logic signed [INR_W-1:0]  inner;
		logic                     ineg;
		logic [IM_W-1:0]          im;
		logic                     cap;
		logic [IN_W-1:0]          rb;
		logic [QB_W-1:0]          qb;
		logic signed [TM_W-1:0]   term;
		logic signed [SUM_W-1:0]  sum;
		logic signed [SCORE_W-1:0] sc;
		logic                     sat;
	} pipe_t;

	function automatic logic [4:0] msb_idx(input logic [IN_W-1:0] v);
		logic [4:0] p;
		p = '0;
		for (int i = 1; i < IN_W; i++) begin
			if (v[i]) p = 5'(i);
		end
		return p;
	endfunction

	function automatic logic [LOG_Q:0] norm_mant(input logic [IN_W-1:0] v, input logic [4:0] p);
		logic [2*IN_W-1:0] w;
		if (p <= 5'(LOG_Q)) begin
			w = {{IN_W{1'b0}}, v} << (5'(LOG_Q) - p);
		end else begin
			w = {{IN_W{1'b0}}, v} >> (p - 5'(LOG_Q));
		end
		return w[LOG_Q:0];
	endfunction

	function automatic logic [LOG_Q+1:0] sq_step(input logic [LOG_Q:0] m);
		logic [2*LOG_Q+1:0] s;
		logic [LOG_Q+1:0]   t;
		s = m * m;
		t = s[2*LOG_Q+1:LOG_Q];
		if (t[LOG_Q+1]) begin
			return {1'b1, t[LOG_Q+1:1]};
		end
		return {1'b0, t[LOG_Q:0]};
	endfunction

	logic [ALPHA_BITS-1:0] tail_q;
	pipe_t                 pl_s  [0:ST_OUT];
	logic                  vld_s [0:ST_OUT];
	logic                  adv;
	pipe_t                 d0;
	logic [IN_W:0]         diff;
	logic                  hit;

	assign adv      = !vld_s[ST_OUT] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= TAIL_RESET;
		end else if (cfg_we) begin
			tail_q <= cfg_wdata;
		end
	end

	always_comb begin
		d0      = '0;
		diff    = {var_forecast[IN_W-1], var_forecast} - {realized_return[IN_W-1], realized_return};
		hit     = realized_return <= var_forecast;
		d0.inv  = !es_forecast[IN_W-1];
		d0.es   = es_forecast;
		d0.vr   = var_forecast;
		d0.a    = (tail_q == '0) ? ALPHA_BITS'(1) : tail_q;
		d0.e    = ~es_forecast + 1'b1;
		d0.qa   = hit ? {diff[IN_W-1:0], ALPHA_BITS'(0)} : '0;
		d0.v2   = ~d0.a + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= ST_OUT; i++) vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i <= ST_OUT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) pl_s[0] <= d0;
	end

	for (genvar k = 1; k <= ST_OUT; k++) begin : g_stage
		pipe_t nx;

		always_comb begin
			logic [ALPHA_BITS:0]  ta;
			logic [IN_W:0]        tb;
			logic [LOG_Q+1:0]     st;
			logic [6:0]           d;
			logic [LOG_Q+6:0]     lv;
			logic [LOG_Q+6:0]     lm;
			logic [PR_W-1:0]      rr;
			logic [LN_W-1:0]      r1;
			logic [TM_W-1:0]      tt;
			ta = '0;
			tb = '0;
			st = '0;
			d  = '0;
			lv = '0;
			lm = '0;
			rr = '0;
			r1 = '0;
			tt = '0;
			nx = pl_s[k-1];
			if (k <= QA_W) begin
				ta = {pl_s[k-1].ra, pl_s[k-1].qa[QA_W-1]};
				if (ta >= {1'b0, pl_s[k-1].a}) begin
					ta    = ta - {1'b0, pl_s[k-1].a};
					nx.qa = {pl_s[k-1].qa[QA_W-2:0], 1'b1};
				end else begin
					nx.qa = {pl_s[k-1].qa[QA_W-2:0], 1'b0};
				end
				nx.ra = ta[ALPHA_BITS-1:0];
			end
			if (k == ST_NORM) begin
				nx.p1 = msb_idx(pl_s[k-1].e);
				nx.m1 = norm_mant(pl_s[k-1].e, nx.p1);
				nx.p2 = msb_idx(IN_W'(pl_s[k-1].v2));
				nx.m2 = norm_mant(IN_W'(pl_s[k-1].v2), nx.p2);
			end
			if (k > ST_NORM && k <= ST_NORM + LOG_Q) begin
				st    = sq_step(pl_s[k-1].m1);
				nx.m1 = st[LOG_Q:0];
				nx.f1 = {pl_s[k-1].f1[LOG_Q-2:0], st[LOG_Q+1]};
				st    = sq_step(pl_s[k-1].m2);
				nx.m2 = st[LOG_Q:0];
				nx.f2 = {pl_s[k-1].f2[LOG_Q-2:0], st[LOG_Q+1]};
			end
			if (k == ST_L) begin
				d       = 7'(pl_s[k-1].p1) - 7'(FRAC_BITS);
				lv      = {d, pl_s[k-1].f1};
				lm      = d[6] ? (~lv + 1'b1) : lv;
				nx.n1   = d[6];
				nx.mag1 = lm[MAG_W-1:0];
				d       = 7'(pl_s[k-1].p2) - 7'(ALPHA_BITS);
				lv      = {d, pl_s[k-1].f2};
				lm      = d[6] ? (~lv + 1'b1) : lv;
				nx.n2   = d[6];
				nx.mag2 = lm[MAG_W-1:0];
			end
			if (k == ST_PART) begin
				nx.hi1 = pl_s[k-1].mag1[MAG_W-1:MAG_LO] * LN2_Q28;
				nx.lo1 = pl_s[k-1].mag1[MAG_LO-1:0] * LN2_Q28;
				nx.hi2 = pl_s[k-1].mag2[MAG_W-1:MAG_LO] * LN2_Q28;
				nx.lo2 = pl_s[k-1].mag2[MAG_LO-1:0] * LN2_Q28;
			end
			if (k == ST_PROD) begin
				nx.pr1 = {pl_s[k-1].hi1, MAG_LO'(0)} + PR_W'(pl_s[k-1].lo1);
				nx.pr2 = {pl_s[k-1].hi2, MAG_LO'(0)} + PR_W'(pl_s[k-1].lo2);
			end
			if (k == ST_RND) begin
				rr     = pl_s[k-1].pr1 + (PR_W'(1) << (RND_SH - 1));
				r1     = LN_W'(rr >> RND_SH);
				nx.ln1 = pl_s[k-1].n1 ? -$signed(r1) : $signed(r1);
				rr     = pl_s[k-1].pr2 + (PR_W'(1) << (RND_SH - 1));
				r1     = LN_W'(rr >> RND_SH);
				nx.ln2 = pl_s[k-1].n2 ? -$signed(r1) : $signed(r1);
			end
			if (k == ST_LNSUM) begin
				nx.lns = LS_W'(pl_s[k-1].ln1) + (LS_W'(1) << FRAC_BITS) - LS_W'(pl_s[k-1].ln2);
			end
			if (k == ST_INNER) begin
				nx.inner = INR_W'(pl_s[k-1].es) - INR_W'(pl_s[k-1].vr) + INR_W'(pl_s[k-1].qa);
			end
			if (k == ST_MAG) begin
				nx.ineg = pl_s[k-1].inner[INR_W-1];
				nx.im   = IM_W'(nx.ineg ? -pl_s[k-1].inner : pl_s[k-1].inner);
			end
			if (k == ST_CAP) begin
				nx.cap = (pl_s[k-1].im >> CAP_SH) >= IM_W'(pl_s[k-1].e);
				nx.rb  = IN_W'(pl_s[k-1].im >> CAP_SH);
				nx.qb  = {pl_s[k-1].im[CAP_SH-1:0], FRAC_BITS'(0)};
			end
			if (k > ST_CAP && k <= ST_CAP + QB_W) begin
				tb = {pl_s[k-1].rb, pl_s[k-1].qb[QB_W-1]};
				if (tb >= {1'b0, pl_s[k-1].e}) begin
					tb    = tb - {1'b0, pl_s[k-1].e};
					nx.qb = {pl_s[k-1].qb[QB_W-2:0], 1'b1};
				end else begin
					nx.qb = {pl_s[k-1].qb[QB_W-2:0], 1'b0};
				end
				nx.rb = tb[IN_W-1:0];
			end
			if (k == ST_TERM) begin
				tt      = pl_s[k-1].cap ? (TM_W'(1) << QB_W) : TM_W'(pl_s[k-1].qb);
				nx.term = pl_s[k-1].ineg ? -$signed(tt) : $signed(tt);
			end
			if (k == ST_SUM) begin
				nx.sum = SUM_W'(pl_s[k-1].term) + SUM_W'(pl_s[k-1].lns);
			end
			if (k == ST_OUT) begin
				if (pl_s[k-1].inv) begin
					nx.sc  = '0;
					nx.sat = 1'b0;
				end else if (pl_s[k-1].sum > SUM_MAX) begin
					nx.sc  = SUM_MAX[SCORE_W-1:0];
					nx.sat = 1'b1;
				end else if (pl_s[k-1].sum < SUM_MIN) begin
					nx.sc  = SUM_MIN[SCORE_W-1:0];
					nx.sat = 1'b1;
				end else begin
					nx.sc  = pl_s[k-1].sum[SCORE_W-1:0];
					nx.sat = 1'b0;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) pl_s[k] <= nx;
		end
	end

	assign out_valid = vld_s[ST_OUT];
	assign score     = pl_s[ST_OUT].sc;
	assign invalid   = pl_s[ST_OUT].inv;
	assign saturated = pl_s[ST_OUT].sat;

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("Input was ready while the output stage was stalled.");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> score == '0 && !saturated)
		else $error("An invalid item gave a nonzero score or a saturation flag.");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> score == SUM_MAX[SCORE_W-1:0] ||
			score == SUM_MIN[SCORE_W-1:0])
		else $error("A saturated score is not at a range limit.");

endmodule

// ===== tb/fz0_var_es_loss_top_tb.sv =====
// Self-checking testbench of the FZ0 VaR and ES loss pipeline with random stimulus and stalls.
`timescale 1ns / 1ps

module fz0_var_es_loss_top_tb;
	import fz0ves_pkg::*;

	typedef struct packed {
		logic signed [IN_W-1:0] var_f;
		logic signed [IN_W-1:0] es_f;
		logic signed [IN_W-1:0] ret;
	} forecast_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic                      invalid;
		logic                      saturated;
	} loss_t;

	localparam int LATENCY   = 123;
	localparam int CYC_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ALPHA_BITS-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [IN_W-1:0] var_forecast = '0;
	logic signed [IN_W-1:0] es_forecast = '0;
	logic signed [IN_W-1:0] realized_return = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SCORE_W-1:0] score;
	logic invalid;
	logic saturated;

	fz0_var_es_loss_top i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .var_forecast(var_forecast),
		.es_forecast(es_forecast), .realized_return(realized_return),
		.out_valid(out_valid), .out_ready(out_ready), .score(score),
		.invalid(invalid), .saturated(saturated)
	);

	always #6 clk = ~clk;

	forecast_t pending_forecasts[$];
	loss_t     expected_losses[$];
	logic [ALPHA_BITS-1:0] alpha_q = TAIL_RESET;
	int mismatch_cnt = 0;
	int checked_cnt = 0;
	int accepted_cnt = 0;
	int cycle_cnt = 0;
	int sat_cnt = 0;
	int invalid_cnt = 0;
	int hit_cnt = 0;
	int in_gap = 0;
	int out_gap = 0;
	bit hold_sender = 1'b0;

	function automatic longint ln_q(longint unsigned v, int b);
		int p;
		longint unsigned m;
		longint unsigned frac;
		longint lg;
		longint unsigned mag;
		longint unsigned prod;
		longint unsigned rnd;
		p = 0;
		while (p < 63 && (v >> (p + 1)) != 0)
			p++;
		m = (p <= LOG_Q) ? (v << (LOG_Q - p)) : (v >> (p - LOG_Q));
		frac = 0;
		for (int i = 1; i <= LOG_Q; i++) begin
			m = (m * m) >> LOG_Q;
			if (m >= (64'd2 << LOG_Q)) begin
				m = m >> 1;
				frac |= 64'd1 << (LOG_Q - i);
			end
		end
		lg = longint'(p - b) * (64'sd1 <<< LOG_Q) + longint'(frac);
		mag = (lg < 0) ? longint'(-lg) : lg;
		prod = mag * 64'd186065279;
		rnd = (prod + (64'd1 << (RND_SH - 1))) >> RND_SH;
		return (lg < 0) ? -longint'(rnd) : longint'(rnd);
	endfunction

	function automatic loss_t fz0_loss(forecast_t f, logic [ALPHA_BITS-1:0] alpha);
		loss_t r;
		longint v, e, rt, hit, inner, term, s;
		longint unsigned a, em, im, q, rm, t;
		v = f.var_f;
		e = f.es_f;
		rt = f.ret;
		r = '0;
		if (e >= 0) begin
			r.invalid = 1'b1;
			return r;
		end
		a = (alpha == 0) ? 1 : alpha;
		hit = 0;
		if (rt <= v)
			hit = longint'((longint'(v - rt) << ALPHA_BITS) / a);
		inner = e - v + hit;
		em = -e;
		im = (inner < 0) ? -inner : inner;
		q = im / em;
		rm = im % em;
		if (q >= (64'd1 << CAP_SH))
			t = 64'd1 << QB_W;
		else begin
			t = (q << FRAC_BITS) + ((rm << FRAC_BITS) / em);
			if (t > (64'd1 << QB_W))
				t = 64'd1 << QB_W;
		end
		term = (inner < 0) ? -longint'(t) : longint'(t);
		s = term + ln_q(em, FRAC_BITS) + (64'sd1 <<< FRAC_BITS)
			- ln_q((64'd1 << ALPHA_BITS) - a, ALPHA_BITS);
		if (s > SUM_MAX) begin
			s = SUM_MAX;
			r.saturated = 1'b1;
		end else if (s < SUM_MIN) begin
			s = SUM_MIN;
			r.saturated = 1'b1;
		end
		r.score = s[SCORE_W-1:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 50)
			return 0;
		if (k < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [IN_W-1:0] rand_value();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return IN_W'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
			2: return IN_W'(-int'($urandom_range(1, 1 << 24)));
			3: return IN_W'(-int'($urandom_range(1, 64)));
			4: return {1'b1, 31'($urandom)};
			default: return IN_W'(int'($urandom_range(0, 1 << 28)) - (1 << 27));
		endcase
	endfunction

	function automatic forecast_t rand_forecast();
		forecast_t f;
		f.var_f = rand_value();
		f.es_f = rand_value();
		f.ret = rand_value();
		if ($urandom_range(0, 9) < 8 && f.es_f >= 0)
			f.es_f = -f.es_f - 1;
		if ($urandom_range(0, 2) == 0)
			f.ret = f.var_f - IN_W'($urandom_range(0, 1 << 22));
		return f;
	endfunction

	task automatic queue_forecast(logic [IN_W-1:0] v, logic [IN_W-1:0] e, logic [IN_W-1:0] r);
		forecast_t f;
		f.var_f = v;
		f.es_f = e;
		f.ret = r;
		pending_forecasts.push_back(f);
	endtask

	task automatic drain();
		while (pending_forecasts.size() != 0 || in_valid || expected_losses.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_alpha(logic [ALPHA_BITS-1:0] a);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		alpha_q = a;
	endtask

	task automatic random_items(int n);
		for (int i = 0; i < n; i++)
			pending_forecasts.push_back(rand_forecast());
	endtask

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYC_LIMIT) begin
			$display("Timeout after %0d cycles.", cycle_cnt);
			$display("fz0_var_es_loss_top_tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				loss_t x;
				x = fz0_loss({var_forecast, es_forecast, realized_return}, alpha_q);
				expected_losses.push_back(x);
				accepted_cnt <= accepted_cnt + 1;
				if (realized_return <= var_forecast)
					hit_cnt <= hit_cnt + 1;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (!hold_sender && pending_forecasts.size() != 0) begin
					forecast_t f;
					f = pending_forecasts.pop_front();
					var_forecast <= f.var_f;
					es_forecast <= f.es_f;
					realized_return <= f.ret;
					in_valid <= 1'b1;
					in_gap <= pick_gap();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				loss_t exp_l;
				if (expected_losses.size() == 0) begin
					mismatch_cnt <= mismatch_cnt + 1;
					if (mismatch_cnt < 10)
						$display("Unexpected transfer: score %0d", score);
				end else begin
					exp_l = expected_losses.pop_front();
					checked_cnt <= checked_cnt + 1;
					sat_cnt <= sat_cnt + exp_l.saturated;
					invalid_cnt <= invalid_cnt + exp_l.invalid;
					if (exp_l.score !== score || exp_l.invalid !== invalid
							|| exp_l.saturated !== saturated) begin
						mismatch_cnt <= mismatch_cnt + 1;
						if (mismatch_cnt < 10)
							$display("Mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
								exp_l.score, exp_l.invalid, exp_l.saturated,
								score, invalid, saturated);
					end
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					out_gap <= pick_gap();
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		queue_forecast(32'h7fffffff, 32'h80000000, 32'h80000000);
		queue_forecast(32'h80000000, 32'hffffffff, 32'h7fffffff);
		queue_forecast(32'h0, 32'h0, 32'h0);
		queue_forecast(32'h7fffffff, 32'h7fffffff, 32'h0);
		queue_forecast(32'hfe000000, 32'hfd000000, 32'hfc000000);
		queue_forecast(32'hfe000000, 32'hfd000000, 32'h01000000);
		queue_forecast(32'hfe000000, 32'hfd000000, 32'hfe000000);
		queue_forecast(32'h7fffffff, 32'hffffffff, 32'h80000000);
		queue_forecast(32'h80000000, 32'h80000000, 32'h7fffffff);
		queue_forecast(32'h00000001, 32'h80000001, 32'h00000000);
		queue_forecast(32'h55555555, 32'haaaaaaaa, 32'h55555555);
		queue_forecast(32'haaaaaaaa, 32'hd5555555, 32'haaaaaaab);
		random_items(200);
		drain();
		hold_sender = 1'b1;
		random_items(30);
		repeat (20) @(posedge clk);
		hold_sender = 1'b0;
		write_alpha('0);
		queue_forecast(32'h7fffffff, 32'hffffffff, 32'h80000000);
		queue_forecast(32'h00100000, 32'hff000000, 32'h00000000);
		random_items(150);
		write_alpha('1);
		queue_forecast(32'h7fffffff, 32'h80000000, 32'h80000000);
		random_items(150);
		write_alpha(24'd1);
		random_items(150);
		write_alpha(24'h800000);
		random_items(150);
		write_alpha(24'h555555);
		random_items(100);
		write_alpha(24'haaaaaa);
		random_items(100);
		write_alpha(TAIL_RESET);
		random_items(50);
		drain();
		$display("Checked %0d of %0d transfers under seven tail levels.", checked_cnt, accepted_cnt);
		$display("Hits %0d, invalid %0d, saturated %0d, mismatches %0d.",
			hit_cnt, invalid_cnt, sat_cnt, mismatch_cnt);
		if (mismatch_cnt == 0 && expected_losses.size() == 0)
			$display("fz0_var_es_loss_top_tb OK");
		else
			$display("fz0_var_es_loss_top_tb NOT OK");
		$finish;
	end

endmodule
